@@ sv/sal_pkg.sv @@
// Shared types and constants for the shifting array list.
package sal_pkg;

    localparam int DATA_W = 32;   // entry word width
    localparam int MODE_W = 3;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;    // width of the reported length
    localparam int IDX_W  = 10;   // cell index width, covers the largest store

    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd5;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic                     ins;      // insert: shift up from ins_idx
        logic [IDX_W-1:0]         ins_idx;
        logic signed [DATA_W-1:0] value;
        logic                     del;      // delete front: shift down
        logic                     rd_load;  // capture entry at rd_idx into read chain
        logic [IDX_W-1:0]         rd_idx;
        logic                     rd_shift; // move read chain toward cell 0
    } cell_ctrl_t;

    typedef struct packed {
        logic                     ok;
        logic [LEN_W-1:0]         length;
        logic                     is_empty;
        logic                     is_full;
        logic signed [DATA_W-1:0] read_value;
    } result_t;

endpackage

@@ sv/sal_cell.sv @@
// One storage cell of the list: holds an entry and a read-chain stage.
module sal_cell #(
    parameter int INDEX = 0
) (
    input  logic                              aclk,
    input  sal_pkg::cell_ctrl_t               ctrl,
    input  logic signed [sal_pkg::DATA_W-1:0] lower_entry,  // entry of cell INDEX-1
    input  logic signed [sal_pkg::DATA_W-1:0] upper_entry,  // entry of cell INDEX+1
    input  logic signed [sal_pkg::DATA_W-1:0] upper_rd,     // read chain of cell INDEX+1
    output logic signed [sal_pkg::DATA_W-1:0] entry,
    output logic signed [sal_pkg::DATA_W-1:0] rd
);
    import sal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic signed [DATA_W-1:0] rd_reg, rd_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (MY_IDX == ctrl.ins_idx) begin
                entry_next = ctrl.value;
            end else if (MY_IDX > ctrl.ins_idx) begin
                entry_next = lower_entry;
            end
        end else if (ctrl.del) begin
            entry_next = upper_entry;
        end
    end

    always_comb begin
        rd_next = rd_reg;
        if (ctrl.rd_load) begin
            rd_next = (MY_IDX == ctrl.rd_idx) ? entry_reg : '0;
        end else if (ctrl.rd_shift) begin
            rd_next = upper_rd;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

@@ sv/shifting_array_list.sv @@
// Top level of the shifting array list: cell row, control and result buffer.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tdata: mode, position, value
//  m_      | out | m_tvalid / m_tready    | m_tdata: ok, length, is_empty, is_full,
//          |     |                        |          read_value
//
// Inserts and deletes finish in the cycle of the transfer: every cell loads its
// neighbor in parallel. A rejected read also finishes in the cycle of the transfer.
// A successful read walks the selected entry down the read chain one cell per
// cycle: s_tready stays low until the entry has reached cell 0 and is pushed.
// aresetn clears the count, the control state and the result buffer, not the entries.
// Results sit in a two-deep buffer; s_tready drops when both slots are full.
module shifting_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [2:0] mode, [8:3] position, [40:9] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [0] ok, [7:1] length, [8] is_empty,
                                   // [9] is_full, [41:10] read_value
);
    import sal_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);        // count width
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;   // common compare width

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_READ = 1'b1;

    // Input fields
    logic [MODE_W-1:0]        in_mode;
    logic [POS_W-1:0]         in_pos;
    logic signed [DATA_W-1:0] in_value;

    assign in_mode  = s_tdata[2:0];
    assign in_pos   = s_tdata[8:3];
    assign in_value = s_tdata[40:9];

    // State
    logic [CW-1:0]    count_reg, count_next;
    logic [0:0]       state_reg, state_next;
    logic [POS_W-1:0] walk_reg, walk_next;     // cells left to walk for a read
    result_t          pend_reg, pend_next;     // status of the read in flight
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          skid_reg, skid_next;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Decode
    logic [CMP_W-1:0] pos_c, cnt_c, ins_pos_c;
    logic             is_full_now, is_empty_now;
    logic             do_ins, ins_ok, del_ok, del_front, rd_ok, op_ok;

    assign pos_c        = CMP_W'(in_pos);
    assign cnt_c        = CMP_W'(count_reg);
    assign is_full_now  = (count_reg == CW'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    always_comb begin
        do_ins    = 1'b0;
        ins_pos_c = pos_c;
        del_ok    = 1'b0;
        del_front = 1'b0;
        rd_ok     = 1'b0;
        case (in_mode)
            MODE_INS_AT: begin
                do_ins = 1'b1;
            end
            MODE_INS_FRONT: begin
                do_ins    = 1'b1;
                ins_pos_c = '0;
            end
            MODE_INS_END: begin
                do_ins    = 1'b1;
                ins_pos_c = cnt_c;
            end
            MODE_DEL_FRONT: begin
                del_ok    = !is_empty_now;
                del_front = !is_empty_now;
            end
            MODE_DEL_END: begin
                del_ok = !is_empty_now;
            end
            MODE_READ: begin
                rd_ok = (pos_c < cnt_c);
            end
            default: begin
            end
        endcase
    end

    assign ins_ok = do_ins && !is_full_now && (ins_pos_c <= cnt_c);
    assign op_ok  = ins_ok || del_ok || rd_ok;

    always_comb begin
        count_next = count_reg;
        if (accept && ins_ok) begin
            count_next = count_reg + CW'(1);
        end else if (accept && del_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Status after this transfer; read value filled in later for reads
    result_t res_now;
    always_comb begin
        res_now.ok         = op_ok;
        res_now.length     = LEN_W'(count_next);
        res_now.is_empty   = (count_next == '0);
        res_now.is_full    = (count_next == CW'(CAPACITY));
        res_now.read_value = '0;
    end

    // Cell row
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic signed [DATA_W-1:0] rd_w    [CAPACITY];

    always_comb begin
        ctrl.ins      = accept && ins_ok;
        ctrl.ins_idx  = IDX_W'(ins_pos_c);
        ctrl.value    = in_value;
        ctrl.del      = accept && del_front;
        ctrl.rd_load  = accept && rd_ok;
        ctrl.rd_idx   = IDX_W'(in_pos);
        ctrl.rd_shift = (state_reg == ST_READ) && (walk_reg != '0);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] lower_w, upper_w, upper_rd_w;
        if (i == 0) begin : g_first
            assign lower_w = '0;
        end else begin : g_lower
            assign lower_w = entry_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper_w    = '0;
            assign upper_rd_w = '0;
        end else begin : g_upper
            assign upper_w    = entry_w[i+1];
            assign upper_rd_w = rd_w[i+1];
        end
        sal_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .lower_entry (lower_w),
            .upper_entry (upper_w),
            .upper_rd    (upper_rd_w),
            .entry       (entry_w[i]),
            .rd          (rd_w[i])
        );
    end

    // Read sequencing
    logic    push;
    result_t push_data;

    always_comb begin
        state_next = state_reg;
        walk_next  = walk_reg;
        pend_next  = pend_reg;
        push       = 1'b0;
        push_data  = res_now;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (rd_ok) begin
                        state_next = ST_READ;
                        walk_next  = in_pos;
                        pend_next  = res_now;
                    end else begin
                        push = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (walk_reg == '0) begin
                    // selected entry has reached cell 0
                    push                 = 1'b1;
                    push_data            = pend_reg;
                    push_data.read_value = rd_w[0];
                    state_next           = ST_IDLE;
                end else begin
                    walk_next = walk_reg - POS_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Two-slot result buffer
    logic pop;
    assign pop = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop) begin
            out_valid_next  = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_next       = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            state_reg      <= ST_IDLE;
            walk_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.read_value, out_reg.is_full, out_reg.is_empty,
                       out_reg.length, out_reg.ok};

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking stream testbench for the shifting array list.
module tb_top;
    import sal_pkg::*;

    localparam int CAP          = 64;
    localparam int RAND_OPS     = 2000;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AT      = 300;      // transfers taken before the long receiver hold-off
    localparam int HOLD_CYCLES  = 200;

    // Unused mode codes, expected to be rejected
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } list_op_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [2:0] mode, [8:3] position, [40:9] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [0] ok, [7:1] length, [8] is_empty, [9] is_full,
                                  // [41:10] read_value

    shifting_array_list #(.CAPACITY(CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow list: what the block must hold after each accepted transfer
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_mem [0:CAP-1];
    int unsigned       shadow_len = 0;

    list_op_t op_q[$];        // items waiting to be offered
    result_t  status_q[$];    // expected result for each accepted transfer
    list_op_t cur_op;

    int unsigned sent_cnt   = 0;
    int unsigned seen_cnt   = 0;
    int unsigned err_cnt    = 0;
    int unsigned full_hits  = 0;
    int unsigned empty_hits = 0;
    int unsigned read_hits  = 0;
    int unsigned cyc_cnt    = 0;

    // Insert shifts entries at and above pos up by one
    function automatic logic list_insert(input int unsigned pos, input logic [DATA_W-1:0] word);
        if (shadow_len >= CAP || pos > shadow_len)
            return 1'b0;
        for (int i = shadow_len; i > pos; i--)
            shadow_mem[i] = shadow_mem[i-1];
        shadow_mem[pos] = word;
        shadow_len++;
        return 1'b1;
    endfunction

    // Apply one operation to the shadow list and return the status it reports
    function automatic result_t list_apply(input list_op_t op);
        result_t r;
        r = '0;
        case (op.mode)
            MODE_INS_AT:    r.ok = list_insert(op.pos, op.value);
            MODE_INS_FRONT: r.ok = list_insert(0, op.value);
            MODE_INS_END:   r.ok = list_insert(shadow_len, op.value);
            MODE_DEL_FRONT: begin
                if (shadow_len != 0) begin
                    for (int i = 0; i + 1 < shadow_len; i++)
                        shadow_mem[i] = shadow_mem[i+1];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            MODE_DEL_END: begin
                if (shadow_len != 0) begin
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            MODE_READ: begin
                if (op.pos < shadow_len) begin
                    r.read_value = shadow_mem[op.pos];
                    r.ok = 1'b1;
                end
            end
            default: r.ok = 1'b0;
        endcase
        r.length   = shadow_len[LEN_W-1:0];
        r.is_empty = (shadow_len == 0);
        r.is_full  = (shadow_len == CAP);
        return r;
    endfunction

    // Idle length: mostly short, now and then long, none at all when calm
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h", seen_cnt, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed corner items, then phased random traffic
    // ------------------------------------------------------------------
    int unsigned gen_len = 0;   // list length as seen by the generator

    task automatic push_op(input logic [MODE_W-1:0] mode, input int unsigned pos,
                           input logic [DATA_W-1:0] value);
        list_op_t op;
        op.mode  = mode;
        op.pos   = pos[POS_W-1:0];
        op.value = value;
        op_q.push_back(op);
        // track length only, so that positions can be aimed at the live range
        case (mode)
            MODE_INS_AT:    if (gen_len < CAP && op.pos <= gen_len) gen_len++;
            MODE_INS_FRONT,
            MODE_INS_END:   if (gen_len < CAP) gen_len++;
            MODE_DEL_FRONT,
            MODE_DEL_END:   if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned      phase;
        int unsigned      r;
        int unsigned      pos;
        logic [MODE_W-1:0] mode;

        // empty-list rejects
        push_op(MODE_DEL_FRONT, 0, 32'h0);
        push_op(MODE_DEL_END, 63, 32'hffff_ffff);
        push_op(MODE_READ, 0, 32'h0);
        push_op(MODE_INS_AT, 1, 32'h1111_1111);       // position past length
        push_op(MODE_SPARE6, 63, 32'hffff_ffff);
        push_op(MODE_SPARE7, 0, 32'h0);
        // build a short list with extreme words
        push_op(MODE_INS_AT, 0, 32'h8000_0000);
        push_op(MODE_INS_FRONT, 17, 32'h7fff_ffff);
        push_op(MODE_INS_END, 42, 32'hffff_ffff);
        push_op(MODE_INS_AT, 3, 32'h0000_0000);       // position equal to length appends
        push_op(MODE_INS_AT, 2, 32'h1234_5678);       // middle insert
        push_op(MODE_INS_AT, 6, 32'hdead_beef);       // past length, rejected
        push_op(MODE_SPARE7, 63, 32'h5555_5555);
        // reads at the ends and just past them
        push_op(MODE_READ, 0, 32'hffff_ffff);
        push_op(MODE_READ, 4, 32'h0);
        push_op(MODE_READ, 5, 32'h0);
        push_op(MODE_READ, 63, 32'h0);
        // take it apart again
        push_op(MODE_DEL_FRONT, 63, 32'hffff_ffff);
        push_op(MODE_READ, 0, 32'h0);
        push_op(MODE_DEL_END, 0, 32'h0);
        push_op(MODE_READ, 2, 32'h0);
        push_op(MODE_DEL_END, 0, 32'h0);
        push_op(MODE_DEL_FRONT, 0, 32'h0);
        push_op(MODE_DEL_END, 0, 32'h0);
        push_op(MODE_DEL_END, 0, 32'h0);              // empty again, rejected

        // Random part in phases: fill to full, drain to empty, or mixed
        phase = 0;
        for (int n = 0; n < RAND_OPS; n++) begin
            if (n % 128 == 0)
                phase = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (phase)
                0: mode = (r < 30) ? MODE_INS_AT    : (r < 45) ? MODE_INS_FRONT :
                          (r < 60) ? MODE_INS_END   : (r < 75) ? MODE_READ      :
                          (r < 85) ? MODE_DEL_FRONT : (r < 93) ? MODE_DEL_END   :
                          3'($urandom_range(0, 7));
                1: mode = (r < 10) ? MODE_INS_AT    : (r < 15) ? MODE_INS_FRONT :
                          (r < 20) ? MODE_INS_END   : (r < 40) ? MODE_READ      :
                          (r < 65) ? MODE_DEL_FRONT : (r < 92) ? MODE_DEL_END   :
                          3'($urandom_range(0, 7));
                default: mode = (r < 20) ? MODE_INS_AT    : (r < 32) ? MODE_INS_FRONT :
                                (r < 44) ? MODE_INS_END   : (r < 70) ? MODE_READ      :
                                (r < 82) ? MODE_DEL_FRONT : (r < 94) ? MODE_DEL_END   :
                                3'($urandom_range(0, 7));
            endcase
            pos = $urandom_range(0, 63);
            if ($urandom_range(0, 99) < 85) begin
                if (mode == MODE_INS_AT)
                    pos = $urandom_range(0, (gen_len < 63) ? gen_len : 63);
                else if (mode == MODE_READ && gen_len > 0)
                    pos = $urandom_range(0, gen_len - 1);
            end
            push_op(mode, pos, pick_value());
        end
    end

    // Reset: held low from the start, released once
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offer queued items, predict on each accepted transfer
    // ------------------------------------------------------------------
    int unsigned drv_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                status_q.push_back(list_apply(cur_op));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap  <= drv_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (op_q.size() > 0) begin
                    cur_op   = op_q.pop_front();
                    s_tdata  <= {7'd0, cur_op.value, cur_op.pos, cur_op.mode};
                    s_tvalid <= 1'b1;
                    // every fourth stretch of 256 transfers goes without idling
                    drv_gap  <= pick_gap(((sent_cnt / 256) % 4) == 1);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls plus one long hold-off that backs the
    // block up until s_tready drops while the sender keeps offering
    // ------------------------------------------------------------------
    int unsigned rdy_gap   = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rdy_gap   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rdy_gap > 0) begin
            rdy_gap  <= rdy_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rdy_gap  <= pick_gap(((cyc_cnt / 4096) % 4) == 2);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected transfer, tdata", m_tdata, 0);
            end else begin
                want = status_q.pop_front();
                if (m_tdata[0] !== want.ok)
                    report_mismatch("ok", m_tdata[0], want.ok);
                if (m_tdata[7:1] !== want.length)
                    report_mismatch("length", m_tdata[7:1], want.length);
                if (m_tdata[8] !== want.is_empty)
                    report_mismatch("is_empty", m_tdata[8], want.is_empty);
                if (m_tdata[9] !== want.is_full)
                    report_mismatch("is_full", m_tdata[9], want.is_full);
                if (m_tdata[41:10] !== want.read_value)
                    report_mismatch("read_value", m_tdata[41:10], want.read_value);
                if (want.is_full)
                    full_hits++;
                if (want.is_empty)
                    empty_hits++;
                if (want.ok && m_tdata[41:10] === want.read_value && want.read_value != 0)
                    read_hits++;
            end
            seen_cnt++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cyc_cnt, status_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // End of run: all items taken, all results back, then a short drain
    initial begin
        @(posedge aresetn);
        while (op_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (status_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (status_q.size() != 0)
            report_mismatch("results left over, count", status_q.size(), 0);
        $display("Run covered %0d transfers in, %0d results out, in %0d cycles",
                 sent_cnt, seen_cnt, cyc_cnt);
        $display("List status: full %0d times, empty %0d times, %0d nonzero reads",
                 full_hits, empty_hits, read_hits);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Mismatches: %0d", err_cnt);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
